// File: rtl/cgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgd_pkg
// Shared types, widths and an arithmetic helper for the complex transposed
// matrix-vector dot unit.
// ----------------------------------------------------------------------------
package cgd_pkg;

  localparam int DATA_W     = 16;
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 12;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = DATA_W + COEF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int BETA_SHIFT = DATA_W - 1 - COEF_FRAC;
  localparam int BETA_W     = SUM_W + BETA_SHIFT;
  localparam int TERM_W     = 2 * DATA_W + 1;
  localparam int CFG_ADDR_W = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_RE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_IM = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_BETA_RE  = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_BETA_IM  = CFG_ADDR_W'(3);

  typedef struct packed {
    logic signed [DATA_W-1:0] mat_re;
    logic signed [DATA_W-1:0] mat_im;
    logic signed [DATA_W-1:0] vec_re;
    logic signed [DATA_W-1:0] vec_im;
    logic signed [DATA_W-1:0] init_re;
    logic signed [DATA_W-1:0] init_im;
    logic                     first_term;
    logic                     last_term;
  } item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] alpha_re;
    logic signed [COEF_W-1:0] alpha_im;
    logic signed [COEF_W-1:0] beta_re;
    logic signed [COEF_W-1:0] beta_im;
  } coef_t;

  // round half up at the coefficient point, then clamp to the data range
  function automatic logic signed [DATA_W-1:0] round_sat(input logic [SUM_W-1:0] s);
    logic signed [SUM_W:0]              t;
    logic signed [SUM_W-COEF_FRAC:0]    r;
    logic signed [SUM_W-COEF_FRAC:0]    hi;
    logic signed [SUM_W-COEF_FRAC:0]    lo;
    t  = $signed({s[SUM_W-1], s}) + $signed((SUM_W+1)'(1) <<< (COEF_FRAC - 1));
    r  = t[SUM_W:COEF_FRAC];
    hi = (SUM_W-COEF_FRAC+1)'((1 << (DATA_W - 1)) - 1);
    lo = -hi - (SUM_W-COEF_FRAC+1)'(1);
    if (r > hi) begin
      return hi[DATA_W-1:0];
    end else if (r < lo) begin
      return lo[DATA_W-1:0];
    end else begin
      return r[DATA_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/cgd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgd_front
// Input side: takes stream transfers, splits the bus into fields, adds the
// flags and holds the items in a short queue until the datapath takes them.
// ----------------------------------------------------------------------------
module cgd_front
  import cgd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [6*DATA_W-1:0]     s_axis_tdata,
  input  wire logic                    s_axis_tuser,
  input  wire logic                    s_axis_tlast,
  output logic                         q_valid,
  input  wire logic                    q_ready,
  output item_t                        q_item
);

  item_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic               push;
  logic               pop;
  item_t              in_item;

  always_comb begin
    in_item.mat_re     = s_axis_tdata[1*DATA_W-1:0*DATA_W];
    in_item.mat_im     = s_axis_tdata[2*DATA_W-1:1*DATA_W];
    in_item.vec_re     = s_axis_tdata[3*DATA_W-1:2*DATA_W];
    in_item.vec_im     = s_axis_tdata[4*DATA_W-1:3*DATA_W];
    in_item.init_re    = s_axis_tdata[5*DATA_W-1:4*DATA_W];
    in_item.init_im    = s_axis_tdata[6*DATA_W-1:5*DATA_W];
    in_item.first_term = s_axis_tuser;
    in_item.last_term  = s_axis_tlast;
  end

  assign s_axis_tready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid       = (count != '0);
  assign q_item        = mem[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + (QPTR_W+1)'(1)) &&
                       (wr_ptr == $past(wr_ptr) + QPTR_W'(1)))
    else $error("queue push bookkeeping off");

endmodule
`default_nettype wire

// File: rtl/cgd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgd_back
// Datapath: alpha*x and beta*y products, rounding, matrix products and the
// 48-bit complex accumulator, with a registered result stage.
// ----------------------------------------------------------------------------
module cgd_back
  import cgd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire coef_t                  coef,
  input  wire logic                   q_valid,
  output logic                        q_ready,
  input  wire item_t                  q_item,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [2*ACC_W-1:0]          m_axis_tdata
);

  logic en;

  // stage a: coefficient products
  logic                      a_valid;
  logic                      a_first;
  logic                      a_last;
  logic signed [DATA_W-1:0]  a_mat_re;
  logic signed [DATA_W-1:0]  a_mat_im;
  logic signed [PROD_W-1:0]  a_xrr, a_xii, a_xri, a_xir;
  logic signed [PROD_W-1:0]  a_yrr, a_yii, a_yri, a_yir;

  // stage b: rounded alpha*x, aligned beta*y
  logic                      b_valid;
  logic                      b_first;
  logic                      b_last;
  logic signed [DATA_W-1:0]  b_mat_re;
  logic signed [DATA_W-1:0]  b_mat_im;
  logic signed [DATA_W-1:0]  b_ax_re;
  logic signed [DATA_W-1:0]  b_ax_im;
  logic [BETA_W-1:0]         b_by_re;
  logic [BETA_W-1:0]         b_by_im;

  // stage c: matrix products
  logic                      c_valid;
  logic                      c_first;
  logic                      c_last;
  logic [BETA_W-1:0]         c_by_re;
  logic [BETA_W-1:0]         c_by_im;
  logic signed [PROD_W-1:0]  c_rr, c_ii, c_ri, c_ir;

  logic [SUM_W-1:0]          xs_re, xs_im, ys_re, ys_im;
  logic [TERM_W-1:0]         t_re, t_im;
  logic [ACC_W-1:0]          acc_re, acc_im;
  logic [ACC_W-1:0]          base_re, base_im;
  logic [ACC_W-1:0]          acc_re_next, acc_im_next;
  logic [ACC_W-1:0]          sum_re, sum_im;

  assign en      = !m_axis_tvalid || m_axis_tready;
  assign q_ready = en;

  always_comb begin
    xs_re = {a_xrr[PROD_W-1], a_xrr} - {a_xii[PROD_W-1], a_xii};
    xs_im = {a_xri[PROD_W-1], a_xri} + {a_xir[PROD_W-1], a_xir};
    ys_re = {a_yrr[PROD_W-1], a_yrr} - {a_yii[PROD_W-1], a_yii};
    ys_im = {a_yri[PROD_W-1], a_yri} + {a_yir[PROD_W-1], a_yir};
    t_re  = {c_rr[PROD_W-1], c_rr} - {c_ii[PROD_W-1], c_ii};
    t_im  = {c_ri[PROD_W-1], c_ri} + {c_ir[PROD_W-1], c_ir};
    // a first item reseeds the accumulator from beta*y
    base_re = c_first ? {{(ACC_W-BETA_W){c_by_re[BETA_W-1]}}, c_by_re} : acc_re;
    base_im = c_first ? {{(ACC_W-BETA_W){c_by_im[BETA_W-1]}}, c_by_im} : acc_im;
    acc_re_next = base_re + {{(ACC_W-TERM_W){t_re[TERM_W-1]}}, t_re};
    acc_im_next = base_im + {{(ACC_W-TERM_W){t_im[TERM_W-1]}}, t_im};
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      a_first  <= q_item.first_term;
      a_last   <= q_item.last_term;
      a_mat_re <= q_item.mat_re;
      a_mat_im <= q_item.mat_im;
      a_xrr    <= coef.alpha_re * q_item.vec_re;
      a_xii    <= coef.alpha_im * q_item.vec_im;
      a_xri    <= coef.alpha_re * q_item.vec_im;
      a_xir    <= coef.alpha_im * q_item.vec_re;
      a_yrr    <= coef.beta_re * q_item.init_re;
      a_yii    <= coef.beta_im * q_item.init_im;
      a_yri    <= coef.beta_re * q_item.init_im;
      a_yir    <= coef.beta_im * q_item.init_re;

      b_first  <= a_first;
      b_last   <= a_last;
      b_mat_re <= a_mat_re;
      b_mat_im <= a_mat_im;
      b_ax_re  <= round_sat(xs_re);
      b_ax_im  <= round_sat(xs_im);
      b_by_re  <= {ys_re, BETA_SHIFT'(0)};
      b_by_im  <= {ys_im, BETA_SHIFT'(0)};

      c_first  <= b_first;
      c_last   <= b_last;
      c_by_re  <= b_by_re;
      c_by_im  <= b_by_im;
      c_rr     <= b_ax_re * b_mat_re;
      c_ii     <= b_ax_im * b_mat_im;
      c_ri     <= b_ax_re * b_mat_im;
      c_ir     <= b_ax_im * b_mat_re;

      if (c_valid && c_last) begin
        sum_re <= acc_re_next;
        sum_im <= acc_im_next;
      end
    end
  end

  // control and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      c_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      acc_re        <= '0;
      acc_im        <= '0;
    end else if (en) begin
      a_valid       <= q_valid;
      b_valid       <= a_valid;
      c_valid       <= b_valid;
      m_axis_tvalid <= c_valid && c_last;
      if (c_valid) begin
        acc_re <= c_last ? '0 : acc_re_next;
        acc_im <= c_last ? '0 : acc_im_next;
      end
    end
  end

  assign m_axis_tdata = {sum_im, sum_re};

  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (en && c_valid && c_last) |=> (acc_re == '0) && (acc_im == '0) && m_axis_tvalid)
    else $error("accumulator not cleared after result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(a_valid) && $stable(b_valid) && $stable(c_valid) &&
            $stable(acc_re) && $stable(acc_im))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// File: rtl/complex_gemv_transpose_dot_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// complex_gemv_transpose_dot_unit
// Complex y_j = beta*y_j + sum_i (alpha*x_i)*A[i][j], one column per run.
// ----------------------------------------------------------------------------
// result: the last item passes the queue, stages a, b, c and the result register
// throughput: one item per cycle; the four-stage multiply/accumulate pipeline
//   advances whenever its result register is empty or being taken, and the
//   4-entry input queue absorbs input while it is held
// reset: synchronous; clears queue, pipeline valids, accumulator, result valid;
//   alpha resets to 1.0 (4096), beta to 0
module complex_gemv_transpose_dot_unit
  import cgd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [COEF_W-1:0]      cfg_wdata,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // mat_re, mat_im, vec_re, vec_im, init_re, init_im
  input  wire logic [6*DATA_W-1:0]    s_axis_tdata,
  // first_term
  input  wire logic                   s_axis_tuser,
  // last_term
  input  wire logic                   s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // sum_re, sum_im
  output logic [2*ACC_W-1:0]          m_axis_tdata
);

  coef_t coef;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.alpha_re <= COEF_W'(1 << COEF_FRAC);
      coef.alpha_im <= '0;
      coef.beta_re  <= '0;
      coef.beta_im  <= '0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_ALPHA_RE: coef.alpha_re <= cfg_wdata;
        REG_ALPHA_IM: coef.alpha_im <= cfg_wdata;
        REG_BETA_RE:  coef.beta_re  <= cfg_wdata;
        REG_BETA_IM:  coef.beta_im  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cgd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  cgd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .coef          (coef),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire
